// ----- hw/rtl/cfcl_pkg.sv -----
// ----------------------------------------------------------------------------
// cfcl_pkg: shared types and constants for the crowd cull and LOD core
// Register indexes, channel payload structs and the fixed-point constants
// used by the plane test, the distance test and the speed color ramp.
// ----------------------------------------------------------------------------
package cfcl_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5,
    REG_EYE_POSITION = 3'd6,
    REG_LOOK_TARGET  = 3'd7
  } cfg_reg_t;

  // Center lift of 0.25 m in Q8.8.
  localparam logic signed [16:0] CENTER_LIFT = 17'sd64;
  localparam logic signed [16:0] CENTER_MAX  = 17'sd32767;

  // Sphere radius 0.5 m with 22 fraction bits.
  localparam logic signed [33:0] RADIUS_Q22 = 34'sd2097152;

  // Squared distance limits with 16 fraction bits: 90^2 and 34^2.
  localparam logic [34:0] CULL_D2   = 35'd530841600;
  localparam logic [34:0] SHADOW_D2 = 35'd75759616;

  localparam logic [31:0] HIGHLIGHT_RGBA = 32'hFF33E6FF;

  // Speed heat: H = floor((10*s - 2048) * 128 / 7), clamped to 0..65536.
  localparam logic [15:0] SPEED_OFFSET = 16'd2048;
  localparam logic [16:0] HEAT_MAX     = 17'd65536;
  localparam logic [23:0] DIV7_MUL     = 24'd9586981;   // ceil(2^26 / 7)
  localparam int          DIV7_SHIFT   = 26;

  // Channel = floor((base + floor(slope * H / 2^16)) / 100).
  localparam int CH_R_BASE  = 6425;
  localparam int CH_R_SLOPE = 16575;
  localparam int CH_G_BASE  = 15860;
  localparam int CH_G_SLOPE = -5610;
  localparam int CH_B_BASE  = 17900;
  localparam int CH_B_SLOPE = -11475;
  localparam logic [15:0] DIV100_MUL   = 16'd41944;     // ceil(2^22 / 100)
  localparam int          DIV100_SHIFT = 22;

  typedef struct packed {
    logic [11:0]        slot_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] heading_angle;
    logic [11:0]        agent_speed;
  } agent_t;

  typedef struct packed {
    logic [11:0]        out_slot;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic signed [15:0] out_heading;
    logic               far_lod;
    logic [31:0]        color_rgba;
  } inst_t;

endpackage

// ----- hw/rtl/cfcl_stream_if.sv -----
// ----------------------------------------------------------------------------
// cfcl_stream_if: valid/ready stream channel
// Carries one payload beat per handshake, with source and sink views.
// ----------------------------------------------------------------------------
interface cfcl_stream_if #(
  parameter type payload_t = logic [0:0]
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- hw/rtl/crowd_frustum_cull_lod_core.sv -----
// ----------------------------------------------------------------------------
// crowd_frustum_cull_lod_core: per-agent frustum and distance cull with LOD
// Streams crowd agents, drops those outside the view volume or beyond the
// draw distance, and emits an instance beat with LOD mark and color.
// ----------------------------------------------------------------------------
// Usage. Agents arrive on agent_in, one beat per agent, and visible agents
// leave on inst_out, one beat each; culled agents and agents whose slot is
// not below MAX_AGENTS produce no beat at all. Both channels use valid and
// ready, and a beat moves at a rising edge where both are high.
// The camera is loaded through the write port (cfg_we, cfg_index, cfg_data)
// while the core is empty: six planes, the eye position and the look target.
// The core is a four-register pipeline. An accepted agent moves through the
// stage 1, 2, 3 and 4 registers and is presented on inst_out from stage 4
// until the receiver takes it. One agent can be accepted in every cycle
// unless a stall backs up to agent_in, so throughput is one agent per clock.
// The depth is set by the chain of plane products, plane sums, and the
// multiplies of the color ramp (divide by 7, slope products, divide by 100).
// Each stage holds its beat only when the stage after it is full and stuck,
// so empty slots close up under a stall and nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears all camera registers;
// with all planes zero every agent passes the plane test.
// ----------------------------------------------------------------------------
module crowd_frustum_cull_lod_core #(
  parameter int MAX_AGENTS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [cfcl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [cfcl_pkg::CFG_DATA_W-1:0]       cfg_data,
  cfcl_stream_if.sink                           agent_in,
  cfcl_stream_if.source                         inst_out
);

  import cfcl_pkg::*;

  // One channel byte from its slope product: add the base, then divide the
  // small positive sum by 100 with a reciprocal multiply.
  function automatic logic [7:0] chan_byte(input logic signed [31:0] p,
                                           input int base);
    logic signed [31:0] t;
    logic [31:0]        q;
    t = 32'(base) + (p >>> 16);
    q = 32'(t[15:0]) * 32'(DIV100_MUL);
    return q[DIV100_SHIFT+7:DIV100_SHIFT];
  endfunction

  // --------------------------------------------------------------------------
  // Camera registers.
  // --------------------------------------------------------------------------
  logic [63:0] plane [NUM_PLANES];
  logic [47:0] eye_position;
  logic [12:0] look_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane[i] <= '0;
      end
      eye_position <= '0;
      look_target  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PLANE_LEFT:   plane[0] <= cfg_data;
        REG_PLANE_RIGHT:  plane[1] <= cfg_data;
        REG_PLANE_BOTTOM: plane[2] <= cfg_data;
        REG_PLANE_TOP:    plane[3] <= cfg_data;
        REG_PLANE_NEAR:   plane[4] <= cfg_data;
        REG_PLANE_FAR:    plane[5] <= cfg_data;
        REG_EYE_POSITION: eye_position <= cfg_data[47:0];
        REG_LOOK_TARGET:  look_target  <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables. A stage loads when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || inst_out.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign agent_in.ready = en1;

  // --------------------------------------------------------------------------
  // Stage 1: center, eye deltas, look match, slot range, heat numerator.
  // --------------------------------------------------------------------------
  logic               s1_slot_ok;
  logic               s1_hi;
  logic [11:0]        s1_slot;
  logic signed [15:0] s1_cx, s1_cy, s1_cz, s1_heading;
  logic signed [16:0] s1_dx, s1_dy, s1_dz;
  logic [22:0]        s1_hx;

  logic signed [16:0] cy_lift;
  logic signed [15:0] cy_sat;
  logic [15:0]        speed_x10;
  logic [15:0]        speed_excess;
  logic signed [15:0] eye_x, eye_y, eye_z;

  always_comb begin
    cy_lift      = 17'(agent_in.payload.pos_y) + CENTER_LIFT;
    cy_sat       = (cy_lift > CENTER_MAX) ? 16'(CENTER_MAX) : cy_lift[15:0];
    speed_x10    = 16'(agent_in.payload.agent_speed) * 16'd10;
    speed_excess = (speed_x10 > SPEED_OFFSET) ? (speed_x10 - SPEED_OFFSET) : '0;
    eye_x        = eye_position[15:0];
    eye_y        = eye_position[31:16];
    eye_z        = eye_position[47:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= agent_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_slot    <= agent_in.payload.slot_index;
      s1_slot_ok <= 17'(agent_in.payload.slot_index) < 17'(MAX_AGENTS);
      s1_hi      <= look_target[12] && (look_target[11:0] == agent_in.payload.slot_index);
      s1_cx      <= agent_in.payload.pos_x;
      s1_cy      <= cy_sat;
      s1_cz      <= agent_in.payload.pos_z;
      s1_heading <= agent_in.payload.heading_angle;
      s1_dx      <= 17'(agent_in.payload.pos_x) - 17'(eye_x);
      s1_dy      <= 17'(cy_sat) - 17'(eye_y);
      s1_dz      <= 17'(agent_in.payload.pos_z) - 17'(eye_z);
      s1_hx      <= {speed_excess, 7'd0};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: plane products, squared deltas, heat by reciprocal of 7.
  // --------------------------------------------------------------------------
  logic               s2_slot_ok;
  logic               s2_hi;
  logic [11:0]        s2_slot;
  logic signed [15:0] s2_cx, s2_cy, s2_cz, s2_heading;
  logic signed [31:0] s2_pa [NUM_PLANES];
  logic signed [31:0] s2_pb [NUM_PLANES];
  logic signed [31:0] s2_pc [NUM_PLANES];
  logic signed [15:0] s2_pd [NUM_PLANES];
  logic [32:0]        s2_sx, s2_sy, s2_sz;
  logic [16:0]        s2_h;

  logic [46:0]        heat_prod;
  logic [20:0]        heat_q;
  logic signed [33:0] sq_x, sq_y, sq_z;

  always_comb begin
    heat_prod = 47'(s1_hx) * 47'(DIV7_MUL);
    heat_q    = heat_prod[DIV7_SHIFT+20:DIV7_SHIFT];
    sq_x      = 34'(s1_dx) * 34'(s1_dx);
    sq_y      = 34'(s1_dy) * 34'(s1_dy);
    sq_z      = 34'(s1_dz) * 34'(s1_dz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_slot    <= s1_slot;
      s2_slot_ok <= s1_slot_ok;
      s2_hi      <= s1_hi;
      s2_cx      <= s1_cx;
      s2_cy      <= s1_cy;
      s2_cz      <= s1_cz;
      s2_heading <= s1_heading;
      for (int i = 0; i < NUM_PLANES; i++) begin
        s2_pa[i] <= 32'($signed(plane[i][15:0])) * 32'(s1_cx);
        s2_pb[i] <= 32'($signed(plane[i][31:16])) * 32'(s1_cy);
        s2_pc[i] <= 32'($signed(plane[i][47:32])) * 32'(s1_cz);
        s2_pd[i] <= plane[i][63:48];
      end
      s2_sx <= sq_x[32:0];
      s2_sy <= sq_y[32:0];
      s2_sz <= sq_z[32:0];
      s2_h  <= (heat_q > 21'(HEAT_MAX)) ? HEAT_MAX : heat_q[16:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: plane sums against the radius, distance sum against both
  // limits, channel slope products.
  // --------------------------------------------------------------------------
  logic               s3_slot_ok;
  logic               s3_hi;
  logic               s3_outside;
  logic               s3_too_far;
  logic               s3_far;
  logic [11:0]        s3_slot;
  logic signed [15:0] s3_cx, s3_cy, s3_cz, s3_heading;
  logic signed [31:0] s3_pr, s3_pg, s3_pb;

  logic signed [33:0] plane_sum [NUM_PLANES];
  logic [NUM_PLANES-1:0] plane_out;
  logic [34:0]        dist2;
  logic signed [31:0] heat_s;

  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      plane_sum[i] = 34'(s2_pa[i]) + 34'(s2_pb[i]) + 34'(s2_pc[i])
                   + (34'(s2_pd[i]) <<< 14);
      plane_out[i] = plane_sum[i] < -RADIUS_Q22;
    end
    dist2  = 35'(s2_sx) + 35'(s2_sy) + 35'(s2_sz);
    heat_s = $signed(32'(s2_h));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_slot    <= s2_slot;
      s3_slot_ok <= s2_slot_ok;
      s3_hi      <= s2_hi;
      s3_cx      <= s2_cx;
      s3_cy      <= s2_cy;
      s3_cz      <= s2_cz;
      s3_heading <= s2_heading;
      s3_outside <= |plane_out;
      s3_too_far <= dist2 > CULL_D2;
      s3_far     <= dist2 > SHADOW_D2;
      s3_pr      <= 32'(CH_R_SLOPE) * heat_s;
      s3_pg      <= 32'(CH_G_SLOPE) * heat_s;
      s3_pb      <= 32'(CH_B_SLOPE) * heat_s;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: output register. Only visible agents become valid here.
  // --------------------------------------------------------------------------
  inst_t       s4;
  logic        visible;
  logic [31:0] ramp_rgba;

  always_comb begin
    visible   = v3 && s3_slot_ok && !s3_outside && !s3_too_far;
    ramp_rgba = {8'hFF, chan_byte(s3_pb, CH_B_BASE), chan_byte(s3_pg, CH_G_BASE),
                 chan_byte(s3_pr, CH_R_BASE)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= visible;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4.out_slot    <= s3_slot;
      s4.center_x    <= s3_cx;
      s4.center_y    <= s3_cy;
      s4.center_z    <= s3_cz;
      s4.out_heading <= s3_heading;
      s4.far_lod     <= s3_far;
      s4.color_rgba  <= s3_hi ? HIGHLIGHT_RGBA : ramp_rgba;
    end
  end

  assign inst_out.valid   = v4;
  assign inst_out.payload = s4;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // An accepted agent always lands in the first stage.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    agent_in.valid && agent_in.ready |=> v1)
    else $error("accepted agent did not reach stage 1");

  // A blocked first stage keeps its contents.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    v1 && !en2 |=> v1 && $stable(s1_slot) && $stable(s1_cy))
    else $error("stage 1 changed while blocked");

  // Every emitted instance comes from a slot inside the pool.
  a_slot_in_pool: assert property (@(posedge clk) disable iff (rst)
    inst_out.valid |-> 17'(inst_out.payload.out_slot) < 17'(MAX_AGENTS))
    else $error("instance emitted for a slot outside the pool");

endmodule
